/* hdl/stk_pkg.sv */
// Package for the sorted top-K table: sizes, codes, payload structs.
// No dependencies.
package stk_pkg;

    localparam int Capacity = 64;
    localparam int Factors  = 4;
    localparam int IdxW     = $clog2(Capacity);
    localparam int CntW     = $clog2(Capacity + 1);

    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_UPDATE = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_RANK   = 3'd3,
        CMD_IDAT   = 3'd4,
        CMD_KEYS   = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BADKEY  = 3'd1,
        ST_ZEROCAP = 3'd2,
        ST_DUP     = 3'd3,
        ST_NOTFND  = 3'd4,
        ST_BADRANK = 3'd5
    } t_status;

    typedef logic [Factors*32-1:0] t_row;

    typedef struct packed {
        logic [2:0]         command;
        logic [31:0]        object_id;
        logic [3:0]         key_count;
        logic signed [31:0] key_0;
        logic signed [31:0] key_1;
        logic signed [31:0] key_2;
        logic signed [31:0] key_3;
        logic [3:0]         key_slot;
        logic [7:0]         rank_query;
    } t_in;

    typedef struct packed {
        logic [2:0]         status;
        logic [6:0]         rank;
        logic [31:0]        found_id;
        logic signed [31:0] out_key_0;
        logic signed [31:0] out_key_1;
        logic signed [31:0] out_key_2;
        logic signed [31:0] out_key_3;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH, S_SRCHW, S_DISP, S_TAILRD, S_TAILW, S_PLACE,
        S_UPRD, S_UPCMP, S_DNRD, S_DNCMP, S_SHRD, S_SHWR, S_RDROW, S_RDW,
        S_DONE
    } t_state;

    // signed lexicographic compare over n keys: 1 greater, -1 less, 0 equal
    function automatic logic [1:0] cmp_rows(input t_row a, input t_row b,
                                            input logic [3:0] n);
        logic [1:0] r;
        logic signed [31:0] x, y;
        r = 2'b00;
        for (int i = Factors - 1; i >= 0; i--) begin
            x = a[i*32 +: 32];
            y = b[i*32 +: 32];
            if (i < n && x != y) r = (x > y) ? 2'b01 : 2'b11;
        end
        return r;
    endfunction

endpackage

/* hdl/sorted_top_k_table.sv */
// Sorted top-K table: bounded leaderboard of unique ids kept in descending key order.
// Depends on stk_pkg and stk_mem.
//
// Usage: commands arrive on the input channel (i_in_valid / o_in_stall), one
// result per command leaves on the output channel (o_out_valid / i_out_stall).
// capacity_in_use is set over the APB port at address 0 (reset 64).
// One command at a time: the engine walks the entry memory (one write port,
// one registered read port), one read per cycle. Every command first searches
// for its id, entry by entry from rank 1, and stops at the id or after the
// last entry. Insert, update and remove then move entries one at a time; id at
// rank reads its row. The result sits in an output register; while the
// receiver stalls it holds, and the next command is taken only once the
// result has been transferred.
// Reset empties the table (entry count zero) and needs no clearing pass.
module sorted_top_k_table import stk_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int RowW = 32 + Factors*32;

    t_state r_st, n_st;
    t_in    r_cmd;
    t_out   r_out;
    logic   r_ov;
    logic [6:0] r_capr;
    logic [CntW-1:0] r_total;
    logic [3:0] r_kiu;
    logic [IdxW:0] r_i;      // scan / move position
    logic [IdxW:0] r_pos;    // found position
    logic r_found;
    logic [RowW-1:0] r_row;  // row being moved

    logic we;
    logic [IdxW-1:0] waddr, raddr;
    logic [RowW-1:0] wdata, rdata;

    stk_mem u_mem (.i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
                   .i_raddr(raddr), .o_rdata(rdata));

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {25'd0, r_capr} : 32'd0;

    logic [CntW-1:0] cap;
    assign cap = (r_capr > 7'(Capacity)) ? CntW'(Capacity) : CntW'(r_capr);

    // new keys of an insert
    t_row nk;
    always_comb begin
        nk = '0;
        if (r_cmd.key_count > 4'd0) nk[31:0]   = r_cmd.key_0;
        if (r_cmd.key_count > 4'd1) nk[63:32]  = r_cmd.key_1;
        if (r_cmd.key_count > 4'd2) nk[95:64]  = r_cmd.key_2;
        if (r_cmd.key_count > 4'd3) nk[127:96] = r_cmd.key_3;
    end

    logic [1:0] c_rd;
    assign c_rd = cmp_rows(r_row[RowW-1:32], rdata[RowW-1:32], r_kiu);
    logic [3:0] kc_new;
    assign kc_new = (r_cmd.key_count > r_kiu) ? r_cmd.key_count : r_kiu;

    logic [1:0] slot_i;
    assign slot_i = 2'(r_cmd.key_slot - 4'd1);
    logic [31:0] oldk;
    assign oldk = r_row[32 + 32*slot_i +: 32];

    // command checks
    logic kc_bad, slot_bad, rq_bad, tail_full, tail_beat, at_tail;
    assign kc_bad    = (r_cmd.key_count == 4'd0) || (r_cmd.key_count > 4'(Factors));
    assign slot_bad  = (r_cmd.key_slot == 4'd0) || (r_cmd.key_slot > 4'(Factors));
    assign rq_bad    = (r_cmd.rank_query == 8'd0) || (r_cmd.rank_query > 8'(r_total));
    assign tail_full = (r_total >= cap) && (r_total != '0);
    // full table: beat the last entry or drop
    assign tail_beat = (cmp_rows(nk, rdata[RowW-1:32], r_kiu) == 2'b01);
    assign at_tail   = (r_i + 1'b1 >= (IdxW+1)'(r_total));

    assign o_in_stall  = (r_st != S_IDLE) || r_ov;
    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE:   if (i_in_valid && !o_in_stall) n_st = S_SRCH;
            S_SRCH:   n_st = (r_i >= (IdxW+1)'(r_total) || r_found) ? S_DISP : S_SRCHW;
            S_SRCHW:  n_st = S_SRCH;
            S_DISP: begin
                n_st = S_DONE;
                case (r_cmd.command)
                    CMD_INSERT: if (!kc_bad && r_capr != 7'd0 && !r_found)
                        n_st = tail_full ? S_TAILRD : S_PLACE;
                    CMD_UPDATE: if (!slot_bad && r_found && oldk != r_cmd.key_0)
                        n_st = ($signed(oldk) > $signed(r_cmd.key_0)) ? S_DNRD : S_UPRD;
                    CMD_REMOVE: if (r_found) n_st = S_SHRD;
                    CMD_IDAT:   if (!rq_bad) n_st = S_RDROW;
                    default: ;
                endcase
            end
            S_TAILRD: n_st = S_TAILW;
            S_TAILW:  n_st = tail_beat ? S_PLACE : S_DONE;
            S_PLACE:  n_st = S_UPRD;
            S_UPRD:   n_st = (r_i == '0) ? S_DONE : S_UPCMP;
            S_UPCMP:  n_st = (c_rd == 2'b01) ? S_UPRD : S_DONE;
            S_DNRD:   n_st = at_tail ? S_DONE : S_DNCMP;
            S_DNCMP:  n_st = (c_rd == 2'b11) ? S_DNRD : S_DONE;
            S_SHRD:   n_st = at_tail ? S_DONE : S_SHWR;
            S_SHWR:   n_st = S_SHRD;
            S_RDROW:  n_st = S_RDW;
            S_RDW:    n_st = S_DONE;
            S_DONE:   n_st = S_IDLE;
            default:  n_st = S_IDLE;
        endcase
    end

    // memory access
    always_comb begin
        we = 1'b0;
        waddr = r_i[IdxW-1:0];
        wdata = r_row;
        raddr = r_i[IdxW-1:0];
        case (r_st)
            S_PLACE: we = 1'b1;
            S_UPRD: begin
                raddr = r_i[IdxW-1:0] - 1'b1;
                // moving row reached rank 1
                if (r_i == '0) we = 1'b1;
            end
            S_UPCMP: begin
                we = 1'b1;
                if (c_rd == 2'b01) wdata = rdata;
            end
            S_DNRD: begin
                raddr = r_i[IdxW-1:0] + 1'b1;
                // moving row reached the tail
                if (at_tail) we = 1'b1;
            end
            S_DNCMP: begin
                we = 1'b1;
                if (c_rd == 2'b11) wdata = rdata;
            end
            S_SHRD:  raddr = r_i[IdxW-1:0] + 1'b1;
            S_SHWR: begin
                we = 1'b1;
                wdata = rdata;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ov <= 1'b0;
            r_capr <= 7'd64;
            r_total <= '0;
            r_kiu <= '0;
        end else begin
            r_st <= n_st;
            if (psel && penable && pwrite && paddr == 1'b0) r_capr <= pwdata[6:0];
            if (r_ov && !i_out_stall) r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: if (i_in_valid && !o_in_stall) begin
                    r_cmd <= i_in;
                    r_i <= '0;
                    r_found <= 1'b0;
                    r_out <= '0;
                end
                S_SRCHW: begin
                    if (rdata[31:0] == r_cmd.object_id) begin
                        r_found <= 1'b1;
                        r_pos <= r_i;
                        r_row <= rdata;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_DISP: begin
                    case (r_cmd.command)
                        CMD_INSERT: begin
                            if (kc_bad) r_out.status <= ST_BADKEY;
                            else if (r_capr == 7'd0) r_out.status <= ST_ZEROCAP;
                            else begin
                                r_kiu <= kc_new;
                                if (r_found) r_out.status <= ST_DUP;
                                else begin
                                    r_row <= {nk, r_cmd.object_id};
                                    if (tail_full) begin
                                        r_i <= (IdxW+1)'(r_total - 1'b1);
                                    end else begin
                                        r_i <= (IdxW+1)'(r_total);
                                        r_total <= r_total + 1'b1;
                                    end
                                end
                            end
                        end
                        CMD_UPDATE: begin
                            if (slot_bad) r_out.status <= ST_BADKEY;
                            else if (!r_found) r_out.status <= ST_NOTFND;
                            else if (oldk != r_cmd.key_0) begin
                                r_row[32 + 32*slot_i +: 32] <= r_cmd.key_0;
                                if (r_cmd.key_slot > r_kiu) r_kiu <= r_cmd.key_slot;
                                r_i <= r_pos;
                            end
                        end
                        CMD_REMOVE: begin
                            if (!r_found) r_out.status <= ST_NOTFND;
                            else r_i <= r_pos;
                        end
                        CMD_RANK: begin
                            if (!r_found) r_out.status <= ST_NOTFND;
                            else r_out.rank <= 7'(r_pos + 1'b1);
                        end
                        CMD_IDAT: begin
                            if (rq_bad) r_out.status <= ST_BADRANK;
                            else r_i <= (IdxW+1)'(r_cmd.rank_query - 8'd1);
                        end
                        CMD_KEYS: begin
                            if (!r_found) r_out.status <= ST_NOTFND;
                            else begin
                                r_out.out_key_0 <= r_row[63:32];
                                r_out.out_key_1 <= r_row[95:64];
                                r_out.out_key_2 <= r_row[127:96];
                                r_out.out_key_3 <= r_row[159:128];
                            end
                        end
                        default: ;
                    endcase
                end
                S_UPCMP: begin
                    if (c_rd == 2'b01) r_i <= r_i - 1'b1;
                end
                S_DNCMP: begin
                    if (c_rd == 2'b11) r_i <= r_i + 1'b1;
                end
                S_SHRD: if (at_tail) r_total <= r_total - 1'b1;
                S_SHWR: r_i <= r_i + 1'b1;
                S_RDW:  r_out.found_id <= rdata[31:0];
                S_DONE: r_ov <= 1'b1;
                default: ;
            endcase
        end
    end
endmodule

/* hdl/stk_mem.sv */
// Entry memory of the sorted top-K table: one row holds id and keys.
// Depends on stk_pkg.
module stk_mem import stk_pkg::*; (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [IdxW-1:0]     i_waddr,
    input  logic [32+Factors*32-1:0] i_wdata,
    input  logic [IdxW-1:0]     i_raddr,
    output logic [32+Factors*32-1:0] o_rdata
);
    logic [32+Factors*32-1:0] r_mem [Capacity];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
